// ===== src/krt_pkg.sv =====
`timescale 1ns / 1ps
package krt_pkg;

    localparam int KEY_W   = 27;
    localparam int SCORE_W = 11;
    localparam int REC_W   = KEY_W + SCORE_W;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_FIND   = 3'd2;
    localparam logic [2:0] OP_SORT   = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         position;
        logic [KEY_W-1:0]   out_key;
        logic [SCORE_W-1:0] out_score;
        logic               last;
    } rsp_t;

endpackage

// ===== src/krt_ram.sv =====
`timescale 1ns / 1ps
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/keyed_record_table_with_sort.sv =====
`timescale 1ns / 1ps
// Find, delete and insert scan the table one entry per cycle.
// Delete then shifts later entries down, reading each entry and then writing it one place lower.
// Sort is an exchange sort over the single RAM that puts higher scores first.
// List emits one result per stored record; the receiver cannot stall results.
// Reset clears the record count and control; RAM contents are left undefined.
module keyed_record_table_with_sort
    import krt_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_DECIDE= 9'b000000100,
        S_SHIFT = 9'b000001000,
        S_SRDI  = 9'b000010000,
        S_SRDJ  = 9'b000100000,
        S_SCMP  = 9'b001000000,
        S_SWAP  = 9'b010000000,
        S_LIST  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] hpos_reg, hpos_next;
    logic [REC_W-1:0] hrec_reg, hrec_next;
    logic [REC_W-1:0] irec_reg, irec_next;
    logic          rv_reg, rv_next;
    logic [CW-1:0] rpos_reg, rpos_next;
    logic          ph_reg, ph_next;
    rsp_t          rsp_reg, rsp_next;
    logic          done_reg, done_next;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [REC_W-1:0] wdata, rdata;

    krt_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        hit_next   = hit_reg;
        hpos_next  = hpos_reg;
        hrec_next  = hrec_reg;
        irec_next  = irec_reg;
        rv_next    = 1'b0;
        rpos_next  = rpos_reg;
        ph_next    = ph_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '0;
        raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    i_next   = '0;
                    hit_next = 1'b0;
                    ph_next  = 1'b0;
                    unique case (cmd.operation)
                        OP_INSERT, OP_DELETE, OP_FIND: state_next = S_SCAN;
                        OP_SORT:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                state_next = S_SRDI;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{ST_OK, 6'd0, '0, '0, 1'b1};
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{ST_NOT_FOUND, 6'd0, '0, '0, 1'b1};
                            end
                            else
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                // read address i; its data appears in the next cycle, tagged rpos
                if (i_reg < count_reg)
                begin
                    raddr     = i_reg[AW-1:0];
                    rv_next   = 1'b1;
                    rpos_next = i_reg;
                    i_next    = i_reg + CW'(1);
                end
                if (rv_reg && rdata[REC_W-1 -: KEY_W] == cmd_reg.key)
                begin
                    hit_next  = 1'b1;
                    hpos_next = rpos_reg[AW-1:0];
                    hrec_next = rdata;
                end
                if (i_reg >= count_reg && !rv_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (cmd_reg.operation == OP_INSERT)
                begin
                    if (hit_reg)
                    begin
                        rsp_next = '{ST_DUPLICATE, 6'(hpos_reg),
                                     hrec_reg[REC_W-1 -: KEY_W], hrec_reg[SCORE_W-1:0], 1'b1};
                    end
                    else if (count_reg >= CW'(DEPTH))
                    begin
                        rsp_next = '{ST_FULL, 6'd0, '0, '0, 1'b1};
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[AW-1:0];
                        wdata      = {cmd_reg.key, cmd_reg.score};
                        count_next = count_reg + CW'(1);
                        rsp_next   = '{ST_OK, 6'(count_reg), cmd_reg.key, cmd_reg.score, 1'b1};
                    end
                end
                else if (!hit_reg)
                begin
                    rsp_next = '{ST_NOT_FOUND, 6'd0, '0, '0, 1'b1};
                end
                else
                begin
                    rsp_next = '{ST_OK, 6'(hpos_reg),
                                 hrec_reg[REC_W-1 -: KEY_W], hrec_reg[SCORE_W-1:0], 1'b1};
                    if (cmd_reg.operation == OP_DELETE)
                    begin
                        i_next     = CW'(hpos_reg);
                        ph_next    = 1'b0;
                        count_next = count_reg - CW'(1);
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                // count_reg already reduced: move i+1 to i while i < count
                if (i_reg >= count_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!ph_reg)
                begin
                    raddr   = AW'(i_reg + CW'(1));
                    ph_next = 1'b1;
                end
                else
                begin
                    we      = 1'b1;
                    waddr   = i_reg[AW-1:0];
                    wdata   = rdata;
                    i_next  = i_reg + CW'(1);
                    ph_next = 1'b0;
                end
            end
            S_SRDI:
            begin
                if (i_reg + CW'(1) >= count_reg)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{ST_OK, 6'd0, '0, '0, 1'b1};
                    state_next = S_IDLE;
                end
                else
                begin
                    raddr      = i_reg[AW-1:0];
                    j_next     = i_reg + CW'(1);
                    state_next = S_SRDJ;
                    ph_next    = 1'b0;
                end
            end
            S_SRDJ:
            begin
                if (!ph_reg)
                begin
                    irec_next = rdata;
                end
                if (j_reg >= count_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_SRDI;
                end
                else
                begin
                    raddr      = j_reg[AW-1:0];
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                ph_next = 1'b1;
                if (irec_reg[SCORE_W-1:0] < rdata[SCORE_W-1:0])
                begin
                    hrec_next  = rdata;
                    state_next = S_SWAP;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_SRDJ;
                end
            end
            S_SWAP:
            begin
                // two writes: j gets old i (kept in irec), then i gets old j (kept in hrec)
                we = 1'b1;
                if (!ph_reg)
                begin
                    waddr      = i_reg[AW-1:0];
                    wdata      = hrec_reg;
                    irec_next  = hrec_reg;
                    j_next     = j_reg + CW'(1);
                    ph_next    = 1'b1;
                    state_next = S_SRDJ;
                end
                else
                begin
                    waddr   = j_reg[AW-1:0];
                    wdata   = irec_reg;
                    ph_next = 1'b0;
                end
            end
            S_LIST:
            begin
                if (!ph_reg)
                begin
                    raddr   = i_reg[AW-1:0];
                    ph_next = 1'b1;
                end
                else
                begin
                    done_next = 1'b1;
                    rsp_next  = '{ST_OK, 6'(i_reg), rdata[REC_W-1 -: KEY_W],
                                  rdata[SCORE_W-1:0], (i_reg + CW'(1) == count_reg)};
                    i_next    = i_reg + CW'(1);
                    ph_next   = 1'b0;
                    if (i_reg + CW'(1) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
            done_reg  <= 1'b0;
            ph_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
            done_reg  <= done_next;
            ph_reg    <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        hit_reg  <= hit_next;
        hpos_reg <= hpos_next;
        hrec_reg <= hrec_next;
        irec_reg <= irec_next;
        rpos_reg <= rpos_next;
        rsp_reg  <= rsp_next;
    end

endmodule

// ===== src/krt_checker.sv =====
`timescale 1ns / 1ps
module krt_checker
    import krt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input cmd_t cmd,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // a result marked last is never directly followed by another result while busy
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.last |=> !done || !busy)
        else $error("result after last while busy");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL) |->
        rsp.position == 6'd0 && rsp.out_key == '0 && rsp.out_score == '0)
        else $error("fail result carries record data");

    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.last)
        else $error("error status not last");

    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.operation == OP_FIND || cmd.operation == OP_DELETE
        || cmd.operation == OP_INSERT) |=> busy)
        else $error("search command not started");

endmodule

bind keyed_record_table_with_sort krt_checker u_krt_checker (.*);

// ===== sim/keyed_record_table_with_sort_checker.sv =====
`timescale 1ns / 1ps
module keyed_record_table_with_sort_checker
    import krt_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  cmd_t cmd,
    input  logic done,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending
);

    logic [KEY_W-1:0]   tbl_key   [DEPTH];
    logic [SCORE_W-1:0] tbl_score [DEPTH];
    int                 tbl_count;
    rsp_t               expected_rsps [$];

    function automatic rsp_t mk_rsp(logic [1:0] st, int pos, logic [KEY_W-1:0] k,
                                    logic [SCORE_W-1:0] s, logic lst);
        rsp_t r;
        r.status    = st;
        r.position  = pos[5:0];
        r.out_key   = k;
        r.out_score = s;
        r.last      = lst;
        return r;
    endfunction

    function automatic int lookup(logic [KEY_W-1:0] k);
        int hit;
        hit = -1;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_key[i] == k)
                hit = i;
        return hit;
    endfunction

    // Applies one command to the table copy and queues what it should return.
    task automatic apply_cmd(cmd_t c);
        int p;
        logic [KEY_W-1:0]   tk;
        logic [SCORE_W-1:0] ts;
        p = lookup(c.key);
        case (c.operation)
            OP_INSERT:
                if (p >= 0)
                    expected_rsps.push_back(mk_rsp(ST_DUPLICATE, p, tbl_key[p],
                                                   tbl_score[p], 1'b1));
                else if (tbl_count >= DEPTH)
                    expected_rsps.push_back(mk_rsp(ST_FULL, 0, '0, '0, 1'b1));
                else
                begin
                    tbl_key[tbl_count]   = c.key;
                    tbl_score[tbl_count] = c.score;
                    expected_rsps.push_back(mk_rsp(ST_OK, tbl_count, c.key, c.score, 1'b1));
                    tbl_count++;
                end
            OP_DELETE, OP_FIND:
                if (p < 0)
                    expected_rsps.push_back(mk_rsp(ST_NOT_FOUND, 0, '0, '0, 1'b1));
                else
                begin
                    expected_rsps.push_back(mk_rsp(ST_OK, p, tbl_key[p], tbl_score[p], 1'b1));
                    if (c.operation == OP_DELETE)
                    begin
                        for (int i = p; i + 1 < tbl_count; i++)
                        begin
                            tbl_key[i]   = tbl_key[i+1];
                            tbl_score[i] = tbl_score[i+1];
                        end
                        tbl_count--;
                    end
                end
            OP_SORT:
            begin
                for (int i = 0; i < tbl_count; i++)
                    for (int j = i + 1; j < tbl_count; j++)
                        if (tbl_score[i] < tbl_score[j])
                        begin
                            tk = tbl_key[i];   ts = tbl_score[i];
                            tbl_key[i] = tbl_key[j];   tbl_score[i] = tbl_score[j];
                            tbl_key[j] = tk;   tbl_score[j] = ts;
                        end
                expected_rsps.push_back(mk_rsp(ST_OK, 0, '0, '0, 1'b1));
            end
            OP_LIST:
                if (tbl_count == 0)
                    expected_rsps.push_back(mk_rsp(ST_NOT_FOUND, 0, '0, '0, 1'b1));
                else
                    for (int i = 0; i < tbl_count; i++)
                        expected_rsps.push_back(mk_rsp(ST_OK, i, tbl_key[i], tbl_score[i],
                                                       i + 1 == tbl_count));
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            tbl_count  = 0;
            fail_count = 0;
            expected_rsps.delete();
        end
        else
        begin
            // result first: the item accepted at this edge cannot have answered yet
            if (done)
            begin
                if (expected_rsps.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t unexpected result %p", $realtime, rsp);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%t mismatch: expected %p got %p", $realtime, want, rsp);
                    end
                end
            end
            if (start && !busy)
                apply_cmd(cmd);
        end
        pending = expected_rsps.size();
    end

endmodule

// ===== sim/keyed_record_table_with_sort_tb.sv =====
`timescale 1ns / 1ps
module keyed_record_table_with_sort_tb;
    import krt_pkg::*;

    localparam int DEPTH = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd = '0;
    logic busy, done;
    rsp_t rsp;
    int   fail_count, pending;

    logic [KEY_W-1:0] used_keys [$];
    int   gap_left;
    bit   no_gaps;

    always #4 clk = ~clk;

    keyed_record_table_with_sort #(.DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .busy(busy), .done(done), .rsp(rsp)
    );

    keyed_record_table_with_sort_checker #(.DEPTH(DEPTH)) chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
    );

    // Holds start high until the item is taken; random gaps drop start unless no_gaps.
    task automatic issue(logic [2:0] op, logic [KEY_W-1:0] k, logic [SCORE_W-1:0] s);
        if (!no_gaps && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            gap_left = $urandom_range(1, 17);
            repeat (gap_left) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= '{operation: op, key: k, score: s};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_INSERT)
            used_keys.push_back(k);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return KEY_W'($urandom_range(0, 99999999));
    endfunction

    initial
    begin
        int r;
        logic [2:0] op;
        no_gaps = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-table cases, extremes, duplicates, invalid opcodes, fill to full
        issue(OP_LIST, '0, '0);
        issue(OP_FIND, 27'd5, '0);
        issue(OP_DELETE, 27'd5, '0);
        issue(OP_SORT, '0, '0);
        issue(OP_INSERT, 27'd0, 11'd0);
        issue(OP_INSERT, 27'd99999999, 11'd2000);
        issue(OP_INSERT, 27'h7FFFFFF, 11'h7FF);
        issue(OP_INSERT, 27'd0, 11'd7);
        issue(OP_FIND, 27'd99999999, '0);
        issue(3'd5, 27'd1, 11'd1);
        issue(3'd7, 27'h7FFFFFF, 11'h7FF);
        issue(OP_SORT, '0, '0);
        issue(OP_LIST, '0, '0);
        issue(OP_DELETE, 27'd0, '0);
        for (int i = 0; i < DEPTH; i++)
            issue(OP_INSERT, KEY_W'(1000 + i), SCORE_W'($urandom_range(0, 2000)));
        issue(OP_INSERT, 27'd99999999, 11'd1);
        issue(OP_INSERT, 27'd5555, 11'd1);
        issue(OP_SORT, '0, '0);
        issue(OP_LIST, '0, '0);

        // pause until everything has drained
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        for (int n = 0; n < 180; n++)
        begin
            if (n == 150)
                no_gaps = 1;
            r = $urandom_range(0, 99);
            if (r < 40)      op = OP_INSERT;
            else if (r < 58) op = OP_DELETE;
            else if (r < 78) op = OP_FIND;
            else if (r < 86) op = OP_SORT;
            else if (r < 95) op = OP_LIST;
            else             op = 3'($urandom_range(5, 7));
            if (op == OP_INSERT && $urandom_range(0, 3) != 0)
                issue(op, KEY_W'($urandom_range(0, 27'h7FFFFFF)),
                      SCORE_W'($urandom_range(0, 11'h7FF)));
            else
                issue(op, rand_key(), SCORE_W'($urandom_range(0, 11'h7FF)));
        end
        issue(OP_LIST, '0, '0);
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
